/* src/dpws_pkg.sv */
`timescale 1ns / 1ps

package dpws_pkg;

  // Packet store depth, checksum slot included.
  localparam int unsigned PACKET_DEPTH = 8;
  localparam int unsigned AddrW = $clog2(PACKET_DEPTH);
  localparam int unsigned CntW = $clog2(PACKET_DEPTH + 1);

  localparam int unsigned ByteW = 8;
  localparam int unsigned BitCntW = 4;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 8;

  // Bit counter: start bit pending, then data bits 7 down to 0.
  localparam logic [BitCntW-1:0] BitCntStart = 4'd9;
  localparam logic [BitCntW-1:0] BitCntFirst = 4'd8;
  localparam logic [BitCntW-1:0] BitCntData = 4'd8;

  localparam logic [ByteW-1:0] OneHalfReset = 8'd57;
  localparam logic [ByteW-1:0] ZeroHalfReset = 8'd99;

  localparam logic [AddrW-1:0] LastDataSlot = AddrW'(PACKET_DEPTH - 1);

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_TICK = 1'b1
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ONE_HALF  = 1'b0,
    CFG_ZERO_HALF = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    action_e          action;
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
  } cmd_t;

  typedef struct packed {
    logic             rail_a;
    logic             rail_b;
    logic [ByteW-1:0] half_period;
    logic             packet_done;
    logic             busy_res;
  } res_t;

endpackage

/* src/dpws_if.sv */
`timescale 1ns / 1ps

interface dpws_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output action, output data_byte, output last_byte,
                  input ready);
  modport sink (input valid, input action, input data_byte, input last_byte,
                output ready);
endinterface

interface dpws_out_if;
  logic       valid;
  logic       ready;
  logic       rail_a;
  logic       rail_b;
  logic [7:0] half_period;
  logic       packet_done;
  logic       busy_res;

  modport source (output valid, output rail_a, output rail_b, output half_period,
                  output packet_done, output busy_res, input ready);
  modport sink (input valid, input rail_a, input rail_b, input half_period,
                input packet_done, input busy_res, output ready);
endinterface

/* src/dcc_packet_waveform_serializer.sv */
`timescale 1ns / 1ps

// DCC packet waveform serializer.
// The input channel carries one item per load or timer event. A load item
// (action low) writes a packet byte and folds it into the XOR checksum; a load
// with last_byte set also stores the checksum and starts sending the packet.
// A tick item (action high) marks the end of a timer half period. Every second
// tick chooses the next bit: a 0 start bit, then the byte MSB first, and 1s
// (preamble) while no packet is pending.
// Every item yields exactly one item on the output channel: the rail levels,
// the reload value for the following half periods, a done flag on the tick
// that chose the last packet bit, and a busy flag.
// An accepted item waits in the command queue, and the back end then writes its
// result into the output register, where it is valid. Throughput is one item per
// cycle while the receiver takes results, set by the single execution step in the
// back end, which updates all sequencer state and reads one store entry per cycle.
// A two-entry queue sits between the front end and the back end, and the
// result sits in an output register, so input keeps flowing while a result
// waits; when the receiver stalls, the back end holds and input ready drops as
// soon as both queue entries are taken. Reset empties the queue and the output
// register, restores the reload registers to 57 and 99, and leaves it idle.
module dcc_packet_waveform_serializer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  dpws_in_if.sink                           in_i,
  dpws_out_if.source                        out_o,
  input  logic                              cfg_we_i,
  input  logic [dpws_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [dpws_pkg::CfgDataW-1:0]     cfg_data_i
);

  dpws_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_pop;

  // Front end: accepts and decodes items into the command queue.
  dpws_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  // Back end: runs one command per cycle whenever the result register is free.
  dpws_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_o       (out_o)
  );

`ifndef SYNTHESIS
  // A done flag only comes from a bit choice that ends the packet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.packet_done |-> out_o.rail_b && !out_o.busy_res)
    else $error("packet_done without bit choice at packet end");

  // Two done flags can never arrive in consecutive results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && out_o.packet_done |=>
      !(out_o.valid && out_o.packet_done))
    else $error("back-to-back packet_done");

  // The queue can only be full while the result register is held by the receiver.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid)
    else $error("queue full while output register is empty");
`endif

endmodule

/* src/dpws_front.sv */
`timescale 1ns / 1ps

// Accepts items, decodes them into commands and holds them in a two-entry queue.
module dpws_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  dpws_in_if.sink             in_i,
  output dpws_pkg::cmd_t      cmd_o,
  output logic                cmd_valid_o,
  input  logic                cmd_pop_i
);

  dpws_pkg::cmd_t slot_q [2];
  logic [1:0]     count_q, count_d;
  logic           wr_ptr_q, rd_ptr_q;
  logic           push, pop;
  dpws_pkg::cmd_t cmd_in;

  assign in_i.ready  = (count_q != 2'd2);
  assign push        = in_i.valid && in_i.ready;
  assign pop         = cmd_pop_i && (count_q != 2'd0);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];

  always_comb begin
    cmd_in.action    = dpws_pkg::action_e'(in_i.action);
    cmd_in.data_byte = in_i.data_byte;
    cmd_in.last_byte = in_i.last_byte;
  end

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

/* src/dpws_back.sv */
`timescale 1ns / 1ps

// Executes queued commands: packet store, checksum, bit sequencer, result register.
module dpws_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dpws_pkg::cmd_t                    cmd_i,
  input  logic                              cmd_valid_i,
  output logic                              cmd_pop_o,
  input  logic                              cfg_we_i,
  input  logic [dpws_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [dpws_pkg::CfgDataW-1:0]     cfg_data_i,
  dpws_out_if.source                        out_o
);

  localparam int unsigned AddrW = dpws_pkg::AddrW;
  localparam int unsigned CntW = dpws_pkg::CntW;
  localparam int unsigned ByteW = dpws_pkg::ByteW;
  localparam int unsigned BitCntW = dpws_pkg::BitCntW;

  logic [ByteW-1:0]   store_q [dpws_pkg::PACKET_DEPTH];
  logic [AddrW-1:0]   write_index_q, write_index_d;
  logic [ByteW-1:0]   running_xor_q, running_xor_d;
  logic [CntW-1:0]    packet_length_q, packet_length_d;
  logic [CntW-1:0]    byte_index_q, byte_index_d;
  logic [BitCntW-1:0] bit_counter_q, bit_counter_d;
  logic               second_half_q, second_half_d;
  logic [ByteW-1:0]   reload_q, reload_d;
  logic [ByteW-1:0]   one_half_q, zero_half_q;
  dpws_pkg::res_t     res_q, res_d;
  logic               out_valid_q;

  logic               data_we, sum_we;
  logic [AddrW-1:0]   data_addr, sum_addr;
  logic [ByteW-1:0]   sum_value;
  logic [ByteW-1:0]   cur_byte;
  logic [BitCntW-1:0] bit_idx;
  logic               cur_bit;
  logic               step;

  assign step      = cmd_valid_i && (!out_valid_q || out_o.ready);
  assign cmd_pop_o = step;

  assign cur_byte = (byte_index_q < CntW'(dpws_pkg::PACKET_DEPTH))
                    ? store_q[byte_index_q[AddrW-1:0]] : '0;

  always_comb begin
    write_index_d   = write_index_q;
    running_xor_d   = running_xor_q;
    packet_length_d = packet_length_q;
    byte_index_d    = byte_index_q;
    bit_counter_d   = bit_counter_q;
    second_half_d   = second_half_q;
    reload_d        = reload_q;
    data_we         = 1'b0;
    sum_we          = 1'b0;
    data_addr       = write_index_q;
    sum_addr        = write_index_q;
    sum_value       = running_xor_q;
    bit_idx         = bit_counter_q - 4'd1;
    cur_bit         = 1'b0;
    res_d.packet_done = 1'b0;

    unique case (cmd_i.action)
      dpws_pkg::ACT_LOAD: begin
        if (write_index_q < dpws_pkg::LastDataSlot) begin
          data_we       = 1'b1;
          running_xor_d = running_xor_q ^ cmd_i.data_byte;
          write_index_d = write_index_q + AddrW'(1);
        end
        if (cmd_i.last_byte) begin
          // The checksum lands just behind the data; a full store keeps its slot.
          sum_we          = 1'b1;
          sum_addr        = write_index_d;
          sum_value       = running_xor_d;
          packet_length_d = CntW'(write_index_d) + CntW'(1);
          byte_index_d    = '0;
          bit_counter_d   = dpws_pkg::BitCntStart;
          write_index_d   = '0;
          running_xor_d   = '0;
        end
      end
      dpws_pkg::ACT_TICK: begin
        if (second_half_q) begin
          second_half_d = 1'b0;
        end else begin
          second_half_d = 1'b1;
          if (byte_index_q < packet_length_q) begin
            if (bit_counter_q == dpws_pkg::BitCntStart) begin
              bit_counter_d = dpws_pkg::BitCntFirst;
              reload_d      = zero_half_q;
            end else begin
              bit_counter_d = bit_idx;
              if (bit_idx < dpws_pkg::BitCntData) begin
                cur_bit = cur_byte[bit_idx[2:0]];
              end
              reload_d = cur_bit ? one_half_q : zero_half_q;
            end
            if (bit_counter_d == '0) begin
              bit_counter_d = dpws_pkg::BitCntStart;
              byte_index_d  = byte_index_q + CntW'(1);
              if (byte_index_d >= packet_length_q) begin
                res_d.packet_done = 1'b1;
              end
            end
          end else begin
            reload_d = one_half_q;
          end
        end
      end
      default: ;
    endcase

    res_d.rail_a      = ~second_half_d;
    res_d.rail_b      = second_half_d;
    res_d.half_period = reload_d;
    res_d.busy_res    = (byte_index_d < packet_length_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_index_q   <= '0;
      running_xor_q   <= '0;
      packet_length_q <= '0;
      byte_index_q    <= '0;
      bit_counter_q   <= dpws_pkg::BitCntStart;
      second_half_q   <= 1'b0;
      reload_q        <= dpws_pkg::OneHalfReset;
      out_valid_q     <= 1'b0;
    end else begin
      if (step) begin
        write_index_q   <= write_index_d;
        running_xor_q   <= running_xor_d;
        packet_length_q <= packet_length_d;
        byte_index_q    <= byte_index_d;
        bit_counter_q   <= bit_counter_d;
        second_half_q   <= second_half_d;
        reload_q        <= reload_d;
        out_valid_q     <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_half_q  <= dpws_pkg::OneHalfReset;
      zero_half_q <= dpws_pkg::ZeroHalfReset;
    end else if (cfg_we_i) begin
      unique case (dpws_pkg::cfg_idx_e'(cfg_index_i))
        dpws_pkg::CFG_ONE_HALF:  one_half_q  <= cfg_data_i;
        dpws_pkg::CFG_ZERO_HALF: zero_half_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
    for (int e = 0; e < int'(dpws_pkg::PACKET_DEPTH); e++) begin
      if (step && sum_we && (sum_addr == AddrW'(e))) begin
        store_q[e] <= sum_value;
      end else if (step && data_we && (data_addr == AddrW'(e))) begin
        store_q[e] <= cmd_i.data_byte;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.rail_a      = res_q.rail_a;
  assign out_o.rail_b      = res_q.rail_b;
  assign out_o.half_period = res_q.half_period;
  assign out_o.packet_done = res_q.packet_done;
  assign out_o.busy_res    = res_q.busy_res;

endmodule

/* bench/tb_dcc_packet_waveform_serializer.sv */
`timescale 1ns / 1ps

// Self-checking bench for the DCC packet waveform serializer.
module tb_dcc_packet_waveform_serializer;
  import dpws_pkg::*;

  // Allowance for the queue slot and output register that an accepted item passes through.
  localparam int unsigned ResultLatency = 2;
  // The run is abandoned after this many cycles in which no item moved on either side.
  localparam int unsigned QuietLimit = 1000;
  // The receiver holds off this long once, so that the block fills and stalls its input.
  localparam int unsigned HoldOffCycles = 48;
  // Percentage of cycles in which each side idles at random.
  localparam int unsigned IdlePct = 18;
  localparam int unsigned RandomItems = 1900;
  localparam int unsigned ReloadPhases = 6;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  dpws_in_if  cmd_if ();
  dpws_out_if wave_if ();

  dcc_packet_waveform_serializer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (cmd_if),
    .out_o       (wave_if),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #4 clk_i = ~clk_i;

  // Shared controls. When steady is set, neither side idles; the hold-off request
  // is picked up by the receiver, which counts the stall itself.
  bit          steady = 1'b0;
  bit          hold_off_req = 1'b0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // Expected waveform results, oldest first.
  res_t expected_wave[$];

  // Serializer state as the bench predicts it. The packet store keeps the data bytes
  // and, right after the last one, the XOR checksum.
  logic [ByteW-1:0]   pkt_bytes [PACKET_DEPTH];
  logic [BitCntW-1:0] fill_idx;
  logic [ByteW-1:0]   xor_acc;
  logic [BitCntW-1:0] pkt_len;
  logic [BitCntW-1:0] send_idx;
  logic [BitCntW-1:0] bit_pos;
  logic               late_half;
  logic [ByteW-1:0]   reload_now;
  logic [ByteW-1:0]   one_reload;
  logic [ByteW-1:0]   zero_reload;

  // Applies one item to the predicted state and returns the result it should produce.
  function automatic res_t advance_waveform(input cmd_t c);
    res_t r;
    logic bit_val;
    r.packet_done = 1'b0;
    if (c.action == ACT_LOAD) begin
      // One store entry is always kept free for the checksum; bytes that do not fit
      // are dropped, but a last-byte mark still closes the packet.
      if (fill_idx < PACKET_DEPTH - 1) begin
        pkt_bytes[fill_idx[AddrW-1:0]] = c.data_byte;
        xor_acc = xor_acc ^ c.data_byte;
        fill_idx = fill_idx + 1'b1;
      end
      if (c.last_byte) begin
        if (fill_idx < PACKET_DEPTH) begin
          pkt_bytes[fill_idx[AddrW-1:0]] = xor_acc;
        end
        // Sending restarts from the first byte, even if a packet was in progress.
        pkt_len = fill_idx + 1'b1;
        send_idx = '0;
        bit_pos = BitCntStart;
        fill_idx = '0;
        xor_acc = '0;
      end
    end else if (late_half) begin
      // The second half of a bit only flips the rails.
      late_half = 1'b0;
    end else begin
      late_half = 1'b1;
      if (send_idx < pkt_len) begin
        if (bit_pos == BitCntStart) begin
          // Start bit of a byte is always a zero.
          bit_pos = BitCntFirst;
          reload_now = zero_reload;
        end else begin
          bit_pos = bit_pos - 1'b1;
          bit_val = 1'b0;
          if (bit_pos < BitCntData && send_idx < PACKET_DEPTH) begin
            bit_val = pkt_bytes[send_idx[AddrW-1:0]][bit_pos[2:0]];
          end
          reload_now = bit_val ? one_reload : zero_reload;
        end
        if (bit_pos == '0) begin
          bit_pos = BitCntStart;
          send_idx = send_idx + 1'b1;
          if (send_idx >= pkt_len) begin
            r.packet_done = 1'b1;
          end
        end
      end else begin
        // No packet pending: preamble ones.
        reload_now = one_reload;
      end
    end
    r.rail_a = ~late_half;
    r.rail_b = late_half;
    r.half_period = reload_now;
    r.busy_res = (send_idx < pkt_len);
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("%0t ns: result %0d, %s: got %0d, expected %0d",
             $time, results_seen, what, got, want);
  endtask

  // Offers one item and waits until the block takes it. Valid is left high on
  // return, so back-to-back items keep it asserted without a drop in between.
  task automatic offer_cmd(input cmd_t c);
    if (!steady) begin
      while ($urandom_range(99) < IdlePct) begin
        cmd_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.action    <= c.action;
    cmd_if.data_byte <= c.data_byte;
    cmd_if.last_byte <= c.last_byte;
    do @(posedge clk_i); while (cmd_if.ready !== 1'b1);
    expected_wave.push_back(advance_waveform(c));
    items_sent++;
  endtask

  task automatic send_load(input logic [ByteW-1:0] value, input logic last);
    cmd_t c;
    c.action = ACT_LOAD;
    c.data_byte = value;
    c.last_byte = last;
    offer_cmd(c);
  endtask

  // Tick items carry random payload bits, which the block must ignore.
  task automatic send_ticks(input int unsigned count);
    cmd_t c;
    repeat (count) begin
      c.action = ACT_TICK;
      c.data_byte = ByteW'($urandom);
      c.last_byte = 1'($urandom);
      offer_cmd(c);
    end
  endtask

  task automatic send_packet(input int unsigned n_bytes);
    for (int unsigned i = 0; i < n_bytes; i++) begin
      send_load(ByteW'($urandom), i == n_bytes - 1);
    end
  endtask

  // Ticks the packet out to its last bit, then a little preamble.
  task automatic finish_packet(input int unsigned extra);
    while (send_idx < pkt_len) begin
      send_ticks(1);
    end
    send_ticks(extra);
  endtask

  // Drops valid and waits until every expected result has come back, plus the
  // block's latency, so that nothing is in flight.
  task automatic settle_idle();
    cmd_if.valid <= 1'b0;
    while (expected_wave.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (ResultLatency + 2) @(posedge clk_i);
  endtask

  // Writes both reload registers on consecutive edges; only called while idle.
  task automatic set_reloads(input logic [ByteW-1:0] one_v, input logic [ByteW-1:0] zero_v);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ONE_HALF;
    cfg_data  <= one_v;
    @(posedge clk_i);
    cfg_index <= CFG_ZERO_HALF;
    cfg_data  <= zero_v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    one_reload = one_v;
    zero_reload = zero_v;
  endtask

  // Right after reset the block sends preamble at the reset reload value.
  task automatic test_preamble();
    send_ticks(3);
  endtask

  // Fills the store past its end with extreme byte values; the two surplus bytes
  // are dropped, yet the last-byte mark on the final one still closes the packet.
  task automatic test_full_store();
    send_load(8'hFF, 1'b0);
    send_load(8'h00, 1'b0);
    send_load(8'h80, 1'b0);
    send_load(8'h01, 1'b0);
    send_load(8'hFF, 1'b0);
    send_load(8'h00, 1'b0);
    send_load(8'h7F, 1'b0);
    send_load(8'hAA, 1'b0);
    send_load(8'h55, 1'b1);
    send_ticks(6);
  endtask

  // A new packet closed while another is on the rails restarts sending at byte 0.
  task automatic test_load_while_sending();
    send_load(8'hC3, 1'b1);
    send_ticks(6);
  endtask

  // The receiver stalls for a long stretch while the sender keeps offering, so the
  // internal queue fills and input ready must drop without losing a result.
  task automatic test_back_pressure();
    settle_idle();
    hold_off_req = 1'b1;
    send_packet(3);
    finish_packet(4);
  endtask

  // Random traffic under one reload setting. Most of it is whole packets ticked out
  // to the end; the rest is packets cut short by a new one, loose loads and noise.
  task automatic run_reload_phase(input logic [ByteW-1:0] one_v, input logic [ByteW-1:0] zero_v,
                                  input int unsigned n_items, input bit no_gaps);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned n_bytes;
    cmd_t c;
    settle_idle();
    set_reloads(one_v, zero_v);
    steady = no_gaps;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      // Mostly short packets; the long ones overflow the store now and then.
      n_bytes = ($urandom_range(99) < 15) ? $urandom_range(9, 4) : $urandom_range(3, 1);
      if (pick < 70) begin
        send_packet(n_bytes);
        finish_packet($urandom_range(5, 0));
      end else if (pick < 82) begin
        send_packet(n_bytes);
        send_ticks($urandom_range(40, 1));
      end else if (pick < 92) begin
        repeat ($urandom_range(8, 1)) begin
          c.action = action_e'($urandom_range(1));
          c.data_byte = ByteW'($urandom);
          c.last_byte = ($urandom_range(7) == 0);
          offer_cmd(c);
        end
      end else begin
        // Bytes that never get a last mark: they sit in the store and the checksum
        // until a later packet closes them in.
        repeat ($urandom_range(10, 1)) send_load(ByteW'($urandom), 1'b0);
        send_ticks($urandom_range(20, 1));
      end
    end
    steady = 1'b0;
  endtask

  // Walks the reload registers through their extremes and a random setting; one
  // phase runs with neither side idling.
  task automatic test_reload_settings();
    int unsigned per_phase;
    per_phase = RandomItems / ReloadPhases;
    run_reload_phase(OneHalfReset, ZeroHalfReset, per_phase, 1'b0);
    run_reload_phase(8'd0, 8'd255, per_phase, 1'b0);
    run_reload_phase(8'd255, 8'd0, per_phase, 1'b0);
    run_reload_phase(8'd0, 8'd0, per_phase, 1'b1);
    run_reload_phase(8'd255, 8'd255, per_phase, 1'b0);
    run_reload_phase(ByteW'($urandom), ByteW'($urandom), per_phase, 1'b0);
  endtask

  // Receiver: accepts results at random, or holds off when asked.
  initial begin : wave_receiver
    int unsigned hold_left;
    hold_left = 0;
    wave_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HoldOffCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        wave_if.ready <= 1'b0;
      end else begin
        wave_if.ready <= steady || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // Compares each accepted result with the oldest expectation, field by field.
  always @(posedge clk_i) begin : wave_checker
    res_t want;
    if (rst_ni === 1'b1 && wave_if.valid === 1'b1 && wave_if.ready === 1'b1) begin
      results_seen++;
      if (expected_wave.size() == 0) begin
        flag_mismatch("result with nothing expected, half_period", wave_if.half_period, 0);
      end else begin
        want = expected_wave.pop_front();
        if (wave_if.rail_a !== want.rail_a) begin
          flag_mismatch("rail_a", wave_if.rail_a, want.rail_a);
        end
        if (wave_if.rail_b !== want.rail_b) begin
          flag_mismatch("rail_b", wave_if.rail_b, want.rail_b);
        end
        if (wave_if.half_period !== want.half_period) begin
          flag_mismatch("half_period", wave_if.half_period, want.half_period);
        end
        if (wave_if.packet_done !== want.packet_done) begin
          flag_mismatch("packet_done", wave_if.packet_done, want.packet_done);
        end
        if (wave_if.busy_res !== want.busy_res) begin
          flag_mismatch("busy_res", wave_if.busy_res, want.busy_res);
        end
      end
    end
  end

  // Counts cycles in which no item moves on either channel.
  always @(posedge clk_i) begin
    if ((cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1) ||
        (wave_if.valid === 1'b1 && wave_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QuietLimit);
    $display("[dcc_packet_waveform_serializer] ERROR");
    $finish;
  end

  initial begin : stimulus
    rst_ni           <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_ONE_HALF;
    cfg_data         <= '0;
    cmd_if.valid     <= 1'b0;
    cmd_if.action    <= ACT_LOAD;
    cmd_if.data_byte <= '0;
    cmd_if.last_byte <= 1'b0;

    // Predicted state after reset: idle, preamble at the reset reload values.
    fill_idx = '0;
    xor_acc = '0;
    pkt_len = '0;
    send_idx = '0;
    bit_pos = BitCntStart;
    late_half = 1'b0;
    reload_now = OneHalfReset;
    one_reload = OneHalfReset;
    zero_reload = ZeroHalfReset;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_preamble();
    test_full_store();
    test_load_while_sending();
    test_back_pressure();
    test_reload_settings();

    settle_idle();
    if (mismatches == 0 && expected_wave.size() == 0) begin
      $display("[dcc_packet_waveform_serializer] OK");
    end else begin
      $display("[dcc_packet_waveform_serializer] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
src/dpws_pkg.sv
src/dpws_if.sv
src/dpws_front.sv
src/dpws_back.sv
src/dcc_packet_waveform_serializer.sv
bench/tb_dcc_packet_waveform_serializer.sv
